// ----- rtl/psr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psr_pkg
// shared types and constants of the particle splat rasteriser
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 60;
    localparam int COORD_W      = 10;
    localparam int DEPTH_W      = 15;
    localparam int SIZE_W       = 3;
    localparam int ROWS_W       = 6;
    localparam int CNT_W        = 6;
    localparam int RESULT_LIMIT = 64;
    localparam int ACC_W        = 43;
    localparam int DEN_W        = ACC_W;
    localparam int NUM_W        = 48;
    localparam int QUO_W        = 18;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 15'h7fff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_ORIGIN     = 3'd0,
        CFG_BASIS_RIGHT     = 3'd1,
        CFG_BASIS_UP        = 3'd2,
        CFG_BASIS_FORWARD   = 3'd3,
        CFG_SCREEN_CENTER   = 3'd4,
        CFG_VIEWPORT_NORMAL = 3'd5,
        CFG_VIEWPORT_VOXEL  = 3'd6,
        CFG_SIZE_CONTROL    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_X,
        OP_Y,
        OP_DEPTH
    } t_div_op;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_ACC,
        F_CHECK,
        F_DIV,
        F_FINISH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_TEST
    } t_back_state;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic               is_voxel;
        logic [15:0]        color;
    } t_particle;

    typedef struct packed {
        logic [8:0]         pixel_x;
        logic [8:0]         pixel_y;
        logic [15:0]        pixel_color;
        logic [DEPTH_W-1:0] pixel_depth;
        logic               write_pixel;
        logic               last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [59:0] view_origin;
        logic [47:0] basis_right;
        logic [47:0] basis_up;
        logic [47:0] basis_forward;
        logic [31:0] screen_center;
        logic [39:0] viewport_normal;
        logic [19:0] viewport_voxel;
        logic [17:0] size_control;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic [DEPTH_W-1:0] depth;
        logic [15:0]        color;
        logic [SIZE_W-1:0]  size;
        logic [ROWS_W-1:0]  rows;
    } t_splat;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
        logic             sat;
        logic             rem_nz;
    } t_div_res;

endpackage
`default_nettype wire

// ----- rtl/psr_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psr_div
// restoring divider, one quotient bit per cycle, with a quotient saturation flag
// ----------------------------------------------------------------------------
module psr_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire psr_pkg::t_div_req  i_req,
    output psr_pkg::t_div_res       o_res
);

    localparam int DSH_W = psr_pkg::DEN_W + psr_pkg::QUO_W - 1;
    localparam int CMP_W = psr_pkg::DEN_W + psr_pkg::QUO_W;
    localparam int CW    = $clog2(psr_pkg::QUO_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [psr_pkg::NUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]           r_dsh;
    logic [psr_pkg::QUO_W-1:0]  r_quo;
    logic                       r_sat;
    logic                       fits;

    assign fits = DSH_W'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_dsh <= {i_req.den, {(psr_pkg::QUO_W-1){1'b0}}};
            r_cnt <= CW'(psr_pkg::QUO_W - 1);
            r_sat <= CMP_W'(i_req.num) >= {i_req.den, {psr_pkg::QUO_W{1'b0}}};
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh[psr_pkg::NUM_W-1:0];
            end
            r_quo <= {r_quo[psr_pkg::QUO_W-2:0], fits};
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quo    = r_quo;
    assign o_res.sat    = r_sat;
    assign o_res.rem_nz = |r_rem;

endmodule
`default_nettype wire

// ----- rtl/psr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psr_front
// camera transform, projection, culling and splat sizing of one particle
// ----------------------------------------------------------------------------
module psr_front #(
    parameter int SCREEN_WIDTH  = 512,
    parameter int SCREEN_HEIGHT = 512,
    parameter int MAX_SPLAT     = 4,
    parameter int DEPTH_SCALE   = 32768,
    parameter int NEAR_CLIP     = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire psr_pkg::t_cfg      i_cfg,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire psr_pkg::t_particle i_data,
    input  wire logic               i_hold,
    output logic                    o_push,
    output psr_pkg::t_splat         o_splat,
    input  wire logic               i_full
);

    localparam int AW = psr_pkg::ACC_W;
    localparam logic signed [AW-1:0] NEAR_Q = AW'(NEAR_CLIP) <<< 18;
    localparam logic [psr_pkg::NUM_W-1:0] DEPTH_NUM = psr_pkg::NUM_W'(DEPTH_SCALE) << 18;

    psr_pkg::t_front_state n_state, r_state;
    psr_pkg::t_div_op      r_op;
    psr_pkg::t_div_req     div_req;
    psr_pkg::t_div_res     div_res;

    logic signed [24:0]    r_loc [3];
    logic signed [40:0]    r_prod;
    logic signed [AW-1:0]  r_acc;
    logic signed [AW-1:0]  r_t [3];
    logic [1:0]            r_vec;
    logic [1:0]            r_comp;
    logic                  r_vox;
    logic [15:0]           r_color;
    logic signed [19:0]    r_px;
    logic signed [19:0]    r_py;
    logic                  r_sat;
    logic [psr_pkg::DEPTH_W-1:0] r_depth;

    logic                  take;
    logic [47:0]           bsel;
    logic signed [15:0]    bcomp;
    logic signed [AW-1:0]  sum;
    logic                  near_cull;
    logic [AW-1:0]         abs_x, abs_y;
    logic [19:0]           qmag;
    logic signed [19:0]    qsigned;
    logic                  qneg;
    logic signed [20:0]    sum_u, sum_v;
    logic signed [16:0]    u_pos, v_pos;
    logic signed [16:0]    lim_l, lim_t, lim_r, lim_b;
    logic                  cull, empty;
    logic [psr_pkg::DEPTH_W-1:0] dsh;
    logic [2:0]            smin, smax;
    logic [psr_pkg::SIZE_W-1:0]  size_c, size_f;

    psr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    assign take = (r_state == psr_pkg::F_IDLE) && i_valid && !i_hold;

    // basis component for the current multiply
    always_comb begin
        case (r_vec)
            2'd0:    bsel = i_cfg.basis_right;
            2'd1:    bsel = i_cfg.basis_up;
            default: bsel = i_cfg.basis_forward;
        endcase
        bcomp = bsel[16*r_comp +: 16];
        sum   = (r_comp == 2'd0 ? '0 : r_acc) + {{2{r_prod[40]}}, r_prod};
    end

    assign near_cull = r_t[2] < NEAR_Q;
    assign abs_x     = r_t[0][AW-1] ? AW'(-r_t[0]) : AW'(r_t[0]);
    assign abs_y     = r_t[1][AW-1] ? AW'(-r_t[1]) : AW'(r_t[1]);

    // floor of signed quotient from magnitude result
    always_comb begin
        qneg    = (r_op == psr_pkg::OP_X) ? r_t[0][AW-1] : r_t[1][AW-1];
        qmag    = {2'b00, div_res.quo};
        qsigned = qneg ? -(qmag + 20'(div_res.rem_nz)) : qmag;
    end

    // screen position, viewport cull and splat size
    always_comb begin
        sum_u = $signed({5'b0, i_cfg.screen_center[15:0]}) + {r_px[19], r_px} + 21'sd8;
        sum_v = $signed({5'b0, i_cfg.screen_center[31:16]}) - {r_py[19], r_py} + 21'sd8;
        u_pos = sum_u[20:4];
        v_pos = sum_v[20:4];
        lim_l = $signed({7'b0, i_cfg.viewport_normal[9:0]});
        lim_t = $signed({7'b0, i_cfg.viewport_normal[19:10]});
        if (r_vox) begin
            lim_r = $signed({7'b0, i_cfg.viewport_voxel[9:0]});
            lim_b = $signed({7'b0, i_cfg.viewport_voxel[19:10]});
            smin  = i_cfg.size_control[12:10];
            smax  = i_cfg.size_control[15:13];
        end else begin
            lim_r = $signed({7'b0, i_cfg.viewport_normal[29:20]});
            lim_b = $signed({7'b0, i_cfg.viewport_normal[39:30]});
            smin  = i_cfg.size_control[6:4];
            smax  = i_cfg.size_control[9:7];
        end
        cull = r_sat || (v_pos > lim_b) || (u_pos > lim_r) || (v_pos < lim_t) ||
               (u_pos < lim_l);
        dsh = r_depth >> i_cfg.size_control[3:0];
        if (dsh < psr_pkg::DEPTH_W'(smin)) begin
            size_c = smin;
        end else if (dsh > psr_pkg::DEPTH_W'(smax)) begin
            size_c = smax;
        end else begin
            size_c = dsh[psr_pkg::SIZE_W-1:0];
        end
        size_f = (int'(size_c) > MAX_SPLAT) ? psr_pkg::SIZE_W'(MAX_SPLAT) : size_c;
        empty  = (size_f == '0) || (int'(u_pos) >= SCREEN_WIDTH) ||
                 (int'(v_pos) >= SCREEN_HEIGHT);
        o_splat.u     = u_pos[psr_pkg::COORD_W-1:0];
        o_splat.v     = v_pos[psr_pkg::COORD_W-1:0];
        o_splat.depth = r_depth;
        o_splat.color = r_color;
        o_splat.size  = size_f;
        o_splat.rows  = psr_pkg::ROWS_W'(size_f) << i_cfg.size_control[17:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psr_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_push        = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = psr_pkg::NUM_W'({abs_x, 4'b0});
        div_req.den   = r_t[2];
        unique case (r_state)
            psr_pkg::F_IDLE: begin
                o_ready = !i_hold;
                if (take) begin
                    n_state = psr_pkg::F_MUL;
                end
            end
            psr_pkg::F_MUL: begin
                n_state = psr_pkg::F_ACC;
            end
            psr_pkg::F_ACC: begin
                if (r_comp == 2'd2 && r_vec == 2'd2) begin
                    n_state = psr_pkg::F_CHECK;
                end else begin
                    n_state = psr_pkg::F_MUL;
                end
            end
            psr_pkg::F_CHECK: begin
                if (near_cull) begin
                    n_state = psr_pkg::F_IDLE;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = psr_pkg::F_DIV;
                end
            end
            psr_pkg::F_DIV: begin
                if (div_res.done) begin
                    if (r_op == psr_pkg::OP_DEPTH) begin
                        n_state = psr_pkg::F_FINISH;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = (r_op == psr_pkg::OP_X) ?
                                        psr_pkg::NUM_W'({abs_y, 4'b0}) : DEPTH_NUM;
                    end
                end
            end
            psr_pkg::F_FINISH: begin
                if (cull || empty) begin
                    n_state = psr_pkg::F_IDLE;
                end else if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = psr_pkg::F_IDLE;
                end
            end
            default: n_state = psr_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_loc[0] <= {i_data.pos_x[23], i_data.pos_x} -
                        {{5{i_cfg.view_origin[19]}}, i_cfg.view_origin[19:0]};
            r_loc[1] <= {i_data.pos_y[23], i_data.pos_y} -
                        {{5{i_cfg.view_origin[39]}}, i_cfg.view_origin[39:20]};
            r_loc[2] <= {i_data.pos_z[23], i_data.pos_z} -
                        {{5{i_cfg.view_origin[59]}}, i_cfg.view_origin[59:40]};
            r_vox    <= i_data.is_voxel;
            r_color  <= i_data.color;
            r_vec    <= 2'd0;
            r_comp   <= 2'd0;
        end
        if (r_state == psr_pkg::F_MUL) begin
            r_prod <= r_loc[r_comp] * bcomp;
        end
        if (r_state == psr_pkg::F_ACC) begin
            if (r_comp == 2'd2) begin
                r_t[r_vec] <= sum;
                r_vec      <= r_vec + 2'd1;
                r_comp     <= 2'd0;
            end else begin
                r_acc  <= sum;
                r_comp <= r_comp + 2'd1;
            end
        end
        if (r_state == psr_pkg::F_CHECK) begin
            r_op  <= psr_pkg::OP_X;
            r_sat <= 1'b0;
        end
        if (r_state == psr_pkg::F_DIV && div_res.done) begin
            case (r_op)
                psr_pkg::OP_X: begin
                    r_px  <= qsigned;
                    r_sat <= r_sat | div_res.sat;
                    r_op  <= psr_pkg::OP_Y;
                end
                psr_pkg::OP_Y: begin
                    r_py  <= qsigned;
                    r_sat <= r_sat | div_res.sat;
                    r_op  <= psr_pkg::OP_DEPTH;
                end
                psr_pkg::OP_DEPTH: begin
                    if (div_res.sat || div_res.quo > psr_pkg::QUO_W'(psr_pkg::DEPTH_MAX)) begin
                        r_depth <= psr_pkg::DEPTH_MAX;
                    end else begin
                        r_depth <= div_res.quo[psr_pkg::DEPTH_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/psr_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psr_fifo
// short queue of sized splats between front and back
// ----------------------------------------------------------------------------
module psr_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire psr_pkg::t_splat i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output psr_pkg::t_splat      o_data,
    output logic                 o_empty
);

    localparam int PW = $clog2(psr_pkg::QUEUE_DEPTH);

    psr_pkg::t_splat r_mem [psr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PW:0]     r_count;

    assign o_full  = r_count == (PW+1)'(psr_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/psr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psr_back
// walks each splat's pixels with a depth read-modify-write per pixel
// ----------------------------------------------------------------------------
module psr_back #(
    parameter int SCREEN_WIDTH  = 512,
    parameter int SCREEN_HEIGHT = 512
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    output logic                 o_pop,
    input  wire psr_pkg::t_splat i_splat,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output psr_pkg::t_pixel      o_data,
    output logic                 o_clearing
);

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

    psr_pkg::t_back_state n_state, r_state;

    logic [psr_pkg::DEPTH_W-1:0] mem [CELLS];
    logic [psr_pkg::DEPTH_W-1:0] r_rd;
    logic [AW-1:0]               r_clr_addr;
    psr_pkg::t_splat             r_job;
    logic [psr_pkg::ROWS_W-1:0]  r_row;
    logic [psr_pkg::SIZE_W-1:0]  r_col;
    logic [psr_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_out_valid;
    psr_pkg::t_pixel             r_out;

    logic [10:0]                 x, y;
    logic [AW-1:0]               addr;
    logic                        pass, fire, col_more, row_more, last;
    logic                        we;

    assign x        = {1'b0, r_job.u} + 11'(r_col);
    assign y        = {1'b0, r_job.v} + 11'(r_row);
    assign addr     = AW'(int'(y) * SCREEN_WIDTH + int'(x));
    assign pass     = r_rd <= r_job.depth;
    assign fire     = !r_out_valid || i_ready;
    assign col_more = ((4'(r_col) + 4'd1) < 4'(r_job.size)) &&
                      ((12'(x) + 12'd1) < 12'(SCREEN_WIDTH));
    assign row_more = ((7'(r_row) + 7'd1) < 7'(r_job.rows)) &&
                      ((12'(y) + 12'd1) < 12'(SCREEN_HEIGHT));
    assign last     = (r_cnt == psr_pkg::CNT_W'(psr_pkg::RESULT_LIMIT - 1)) ||
                      (!col_more && !row_more);
    assign we       = (r_state == psr_pkg::B_TEST) && fire && pass;

    assign o_valid    = r_out_valid;
    assign o_data     = r_out;
    assign o_clearing = r_state == psr_pkg::B_CLEAR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psr_pkg::B_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            psr_pkg::B_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = psr_pkg::B_IDLE;
                end
            end
            psr_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = psr_pkg::B_READ;
                end
            end
            psr_pkg::B_READ: begin
                n_state = psr_pkg::B_TEST;
            end
            psr_pkg::B_TEST: begin
                if (fire) begin
                    n_state = last ? psr_pkg::B_IDLE : psr_pkg::B_READ;
                end
            end
            default: n_state = psr_pkg::B_IDLE;
        endcase
    end

    // clear sweep counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == psr_pkg::B_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == psr_pkg::B_TEST && fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_splat;
            r_row <= '0;
            r_col <= '0;
            r_cnt <= '0;
        end
        if (r_state == psr_pkg::B_TEST && fire) begin
            r_out.pixel_x     <= x[8:0];
            r_out.pixel_y     <= y[8:0];
            r_out.pixel_color <= r_job.color;
            r_out.pixel_depth <= r_job.depth;
            r_out.write_pixel <= pass;
            r_out.last_pixel  <= last;
            r_cnt             <= r_cnt + 1'b1;
            if (col_more) begin
                r_col <= r_col + 1'b1;
            end else begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end
        end
    end

    // depth store
    always_ff @(posedge i_clk) begin
        if (r_state == psr_pkg::B_CLEAR) begin
            mem[r_clr_addr] <= '0;
        end else if (we) begin
            mem[addr] <= r_job.depth;
        end
        if (r_state == psr_pkg::B_READ) begin
            r_rd <= mem[addr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/particle_splat_rasterizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// particle_splat_rasterizer
// z-buffered point sprite splatting of particles into pixel transactions
// ----------------------------------------------------------------------------
// One particle transaction goes in, zero to 64 pixel transactions come out in
// raster order, the last one flagged. After reset the depth store is swept to
// zero, all SCREEN_WIDTH*SCREEN_HEIGHT cells (262144 at the defaults), and no
// particle is taken until the sweep ends; configuration writes are taken at
// any time. The front end does the nine camera-space multiplies through one
// shared multiplier, checks the near clip, then does three 18-bit restoring
// divisions (x, y and inverse depth) in one divider and culls or queues the
// splat, waiting while the queue is full; it takes no new particle until it
// is back in idle. The back end reads each pixel's depth through the depth
// store's single port, then tests and writes it, waiting while the pixel
// output is stalled. A four-entry queue between the two lets the front work on
// the next particle while the back draws.
// ----------------------------------------------------------------------------
module particle_splat_rasterizer #(
    parameter int SCREEN_WIDTH  = 512,
    parameter int SCREEN_HEIGHT = 512,
    parameter int MAX_SPLAT     = 4,
    parameter int DEPTH_SCALE   = 32768,
    parameter int NEAR_CLIP     = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // particle channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire psr_pkg::t_particle              i_data,
    // pixel channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output psr_pkg::t_pixel                      o_data,
    // configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [psr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [psr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    psr_pkg::t_cfg   r_cfg;
    psr_pkg::t_splat push_splat, head_splat;
    logic            push, pop, full, empty, clearing;

    // register file, all fields zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (psr_pkg::t_cfg_idx'(i_cfg_idx))
                psr_pkg::CFG_VIEW_ORIGIN:     r_cfg.view_origin     <= i_cfg_data[59:0];
                psr_pkg::CFG_BASIS_RIGHT:     r_cfg.basis_right     <= i_cfg_data[47:0];
                psr_pkg::CFG_BASIS_UP:        r_cfg.basis_up        <= i_cfg_data[47:0];
                psr_pkg::CFG_BASIS_FORWARD:   r_cfg.basis_forward   <= i_cfg_data[47:0];
                psr_pkg::CFG_SCREEN_CENTER:   r_cfg.screen_center   <= i_cfg_data[31:0];
                psr_pkg::CFG_VIEWPORT_NORMAL: r_cfg.viewport_normal <= i_cfg_data[39:0];
                psr_pkg::CFG_VIEWPORT_VOXEL:  r_cfg.viewport_voxel  <= i_cfg_data[19:0];
                psr_pkg::CFG_SIZE_CONTROL:    r_cfg.size_control    <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // transform, project, cull and size
    psr_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_SPLAT     (MAX_SPLAT),
        .DEPTH_SCALE   (DEPTH_SCALE),
        .NEAR_CLIP     (NEAR_CLIP)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_hold  (clearing),
        .o_push  (push),
        .o_splat (push_splat),
        .i_full  (full)
    );

    // decoupling queue
    psr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_splat),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_splat),
        .o_empty (empty)
    );

    // pixel walk and depth test
    psr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .o_pop      (pop),
        .i_splat    (head_splat),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .o_clearing (clearing)
    );

endmodule
`default_nettype wire

// ----- rtl/psr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psr_checker
// port-level checks on the rasteriser, bound to the top level
// ----------------------------------------------------------------------------
module psr_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire psr_pkg::t_pixel i_out_data
);

    // a stalled pixel transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("pixel transaction changed while stalled");

    // no pixel straight after reset
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("pixel valid after reset");

    // depth store sweep blocks particles after reset
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("particle taken during depth store clear");

    // pixels of one splat share depth and colour
    a_same_splat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.last_pixel |=>
        !i_out_valid || ($stable(i_out_data.pixel_depth) &&
                         $stable(i_out_data.pixel_color)))
        else $error("splat pixels disagree");

endmodule

bind particle_splat_rasterizer psr_checker u_psr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_data  (o_data)
);
`default_nettype wire
